FILE: hdl/gmr_pkg.sv
package gmr_pkg;

    // Default sizes of the delay memory and of one audio sample
    localparam int DELAY_DEPTH_DEF  = 4096;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Configuration register widths
    localparam int ROOM_W     = 9;
    localparam int THRESH_W   = 15;
    localparam int ATTACK_W   = 16;
    localparam int HOLD_W     = 20;
    localparam int MIX_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROOM_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_LEVEL      = 3'd4;

    // Configuration reset values
    localparam logic [ROOM_W-1:0]   ROOM_SIZE_RST      = 9'd128;
    localparam logic [THRESH_W-1:0] GATE_THRESHOLD_RST = 15'd328;
    localparam logic [ATTACK_W-1:0] ATTACK_COEFF_RST   = 16'd64225;
    localparam logic [HOLD_W-1:0]   HOLD_SAMPLES_RST   = 20'd4800;
    localparam logic [MIX_W-1:0]    MIX_LEVEL_RST      = 9'd128;

    // Q0.16 coefficients: envelope release 0.99, gate open 0.3, gate close 0.1
    localparam logic [15:0] DECAY_COEFF      = 16'd64881;
    localparam logic [15:0] GATE_OPEN_COEFF  = 16'd19661;
    localparam logic [15:0] GATE_CLOSE_COEFF = 16'd6554;

    // Mix level full scale (Q8 one)
    localparam logic [MIX_W-1:0] MIX_FULL = 9'd256;

    // Gate and mix settings handed to the gain stage
    typedef struct packed {
        logic [THRESH_W-1:0] gate_threshold;
        logic [ATTACK_W-1:0] attack_coeff;
        logic [HOLD_W-1:0]   hold_samples;
        logic [MIX_W-1:0]    mix_level;
    } gmr_gate_cfg_t;

    // Base delay of each tap in samples
    function automatic logic [11:0] tap_base(input logic [1:0] idx);
        logic [11:0] base;
        case (idx)
            2'd0:    base = 12'd1000;
            2'd1:    base = 12'd1500;
            2'd2:    base = 12'd2200;
            default: base = 12'd3000;
        endcase
        return base;
    endfunction

endpackage

FILE: hdl/gmr_delay_line.sv
module gmr_delay_line #(
    parameter int DEPTH = gmr_pkg::DELAY_DEPTH_DEF,
    parameter int SW    = gmr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [SW-1:0]          mono,
    input  logic [gmr_pkg::ROOM_W-1:0]    room_size,
    output logic                          done,
    output logic signed [SW-1:0]          wet
);
    import gmr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] STEP_WRITE      = 3'd0;
    localparam logic [2:0] STEP_FIRST_READ = 3'd1;
    localparam logic [2:0] STEP_FIRST_ACC  = 3'd2;
    localparam logic [2:0] STEP_LAST_DLY   = 3'd3;
    localparam logic [2:0] STEP_LAST_READ  = 3'd4;
    localparam logic [2:0] STEP_LAST       = 3'd5;

    logic                 busy_reg, busy_next;
    logic [2:0]           step_reg, step_next;
    logic                 done_reg, done_next;
    logic [AW-1:0]        wp_reg, wp_next;
    logic                 wrap_reg, wrap_next;
    logic signed [SW-1:0] fb_reg, fb_next;

    logic [AW-1:0]        dly_reg;
    logic signed [SW+1:0] sum_reg;
    logic signed [SW+1:0] sum_next;
    logic signed [SW-1:0] rd_data_reg;
    logic                 rd_ok_reg;
    logic signed [SW-1:0] wet_reg;

    logic signed [SW-1:0] mem [DEPTH];

    logic [21:0]          dly_prod;
    logic [12:0]          dly_raw;
    logic [AW-1:0]        dly_clamped;
    logic [AW:0]          rd_diff;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 rd_ok;
    logic                 wr_en;
    logic signed [SW:0]   wr_sum;
    logic signed [SW-1:0] wr_data;
    logic signed [SW-1:0] tap_val;
    logic                 wp_last;

    // Scale the base delay of the tap picked by the step and clamp below the depth
    assign dly_prod    = 22'(tap_base(step_reg[1:0])) * (22'(room_size) + 22'd256);
    assign dly_raw     = dly_prod[21:9];
    assign dly_clamped = (32'(dly_raw) >= 32'(DEPTH)) ? AW'(DEPTH - 1) : AW'(dly_raw);

    // Tap address behind the write pointer, modulo the depth
    assign rd_diff = {1'b0, wp_reg} - {1'b0, dly_reg};
    assign rd_addr = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(DEPTH)) : rd_diff[AW-1:0];
    assign rd_en   = busy_reg && (step_reg >= STEP_FIRST_READ) && (step_reg <= STEP_LAST_READ);

    // Entries not yet written since reset read as zero
    assign rd_ok   = wrap_reg || (rd_addr < wp_reg);
    assign tap_val = rd_ok_reg ? rd_data_reg : '0;

    // New sample: mono plus half the previous longest tap, saturated
    assign wr_sum  = {mono[SW-1], mono} + {fb_reg[SW-1], fb_reg[SW-1], fb_reg[SW-1:1]};
    assign wr_data = (wr_sum[SW] != wr_sum[SW-1])
                   ? (wr_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
                   : wr_sum[SW-1:0];
    assign wr_en   = busy_reg && (step_reg == STEP_WRITE);

    assign sum_next = ((step_reg == STEP_FIRST_ACC) ? '0 : sum_reg) + (SW+2)'(tap_val);
    assign wp_last  = (wp_reg == AW'(DEPTH - 1));

    // Single memory port: one write, then four reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequence the steps and advance the write pointer at the end
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        wp_next   = wp_reg;
        wrap_next = wrap_reg;
        fb_next   = fb_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_WRITE;
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                fb_next   = tap_val;
                wrap_next = wrap_reg || wp_last;
                wp_next   = wp_last ? '0 : wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_WRITE;
            done_reg <= 1'b0;
            wp_reg   <= '0;
            wrap_reg <= 1'b0;
            fb_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
            wp_reg   <= wp_next;
            wrap_reg <= wrap_next;
            fb_reg   <= fb_next;
        end
    end

    // Hold tap delay, read status and running sum
    always_ff @(posedge aclk) begin
        if (busy_reg && (step_reg <= STEP_LAST_DLY)) begin
            dly_reg <= dly_clamped;
        end
        if (rd_en) begin
            rd_ok_reg <= rd_ok;
        end
        if (busy_reg && (step_reg >= STEP_FIRST_ACC)) begin
            sum_reg <= sum_next;
        end
        if (busy_reg && (step_reg == STEP_LAST)) begin
            wet_reg <= sum_next[SW+1:2];
        end
    end

    assign done = done_reg;
    assign wet  = wet_reg;

endmodule

FILE: hdl/gmr_gate_mix.sv
module gmr_gate_mix #(
    parameter int SW = gmr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [SW-1:0]   wet,
    input  logic signed [SW-1:0]   left_dry,
    input  logic signed [SW-1:0]   right_dry,
    input  gmr_pkg::gmr_gate_cfg_t cfg,
    output logic                   done,
    output logic signed [SW-1:0]   left_out,
    output logic signed [SW-1:0]   right_out
);
    import gmr_pkg::*;

    localparam int MAW = (SW + 1 > 17) ? SW + 1 : 17;
    localparam int PW  = MAW + 18;

    localparam logic [3:0] ST_ENV_MUL0  = 4'd0;
    localparam logic [3:0] ST_ENV_MUL1  = 4'd1;
    localparam logic [3:0] ST_GATE_HOLD = 4'd2;
    localparam logic [3:0] ST_GATE_MUL  = 4'd3;
    localparam logic [3:0] ST_GATE_UPD  = 4'd4;
    localparam logic [3:0] ST_WET_GAIN  = 4'd5;
    localparam logic [3:0] ST_MIX_L     = 4'd6;
    localparam logic [3:0] ST_OUT_L     = 4'd7;
    localparam logic [3:0] ST_MIX_R     = 4'd8;
    localparam logic [3:0] ST_OUT_R     = 4'd9;

    logic                 busy_reg, busy_next;
    logic [3:0]           step_reg, step_next;
    logic                 done_reg, done_next;
    logic [SW-1:0]        env_reg, env_next;
    logic [15:0]          gate_reg, gate_next;
    logic [HOLD_W-1:0]    hold_reg, hold_next;

    logic                 att_reg;
    logic                 open_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [SW-1:0] gw_reg;
    logic signed [SW-1:0] lo_reg;
    logic signed [SW-1:0] ro_reg;

    logic [SW-1:0]         wet_mag;
    logic                  att;
    logic [MIX_W-1:0]      mix_m;
    logic [MIX_W-1:0]      mix_inv;
    logic signed [MAW-1:0] mul_a;
    logic signed [17:0]    mul_b;
    logic signed [PW-1:0]  prod;
    logic [SW-1:0]         env_new;
    logic [HOLD_W-1:0]     hold_eff;
    logic                  gate_open;
    logic [15:0]           gate_step;
    logic signed [PW-1:0]  mix_shift;
    logic                  sat_hi;
    logic                  sat_lo;
    logic signed [SW-1:0]  mix_sat;

    // Magnitude of the wet signal and envelope direction
    assign wet_mag = wet[SW-1] ? (~unsigned'(wet) + 1'b1) : unsigned'(wet);
    assign att     = wet_mag > env_reg;

    // Clamp the mix level at full wet
    assign mix_m   = (cfg.mix_level > MIX_FULL) ? MIX_FULL : cfg.mix_level;
    assign mix_inv = MIX_FULL - mix_m;

    // Operands of the shared multiplier for each step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_ENV_MUL0: begin
                mul_a = MAW'(env_reg);
                mul_b = att ? 18'(cfg.attack_coeff) : 18'(DECAY_COEFF);
            end
            ST_ENV_MUL1: begin
                mul_a = MAW'(wet_mag);
                mul_b = 18'(18'd65536 - 18'(cfg.attack_coeff));
            end
            ST_GATE_MUL: begin
                mul_a = open_reg ? MAW'(GATE_OPEN_COEFF) : MAW'(GATE_CLOSE_COEFF);
                mul_b = open_reg ? 18'(16'hFFFF - gate_reg) : 18'(gate_reg);
            end
            ST_GATE_UPD: begin
                mul_a = MAW'(left_dry);
                mul_b = 18'(mix_inv);
            end
            ST_WET_GAIN: begin
                mul_a = MAW'(wet);
                mul_b = 18'(gate_reg);
            end
            ST_MIX_L, ST_MIX_R: begin
                mul_a = MAW'(gw_reg);
                mul_b = 18'(mix_m);
            end
            ST_OUT_L: begin
                mul_a = MAW'(right_dry);
                mul_b = 18'(mix_inv);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // Envelope result, hold reload and gate direction
    assign env_new   = acc_reg[16 +: SW];
    assign hold_eff  = (32'(env_new) > 32'(cfg.gate_threshold)) ? cfg.hold_samples : hold_reg;
    assign gate_open = (hold_eff != '0);
    assign gate_step = acc_reg[31:16];

    // Scale the mix sum back to Q1.15 and saturate
    assign mix_shift = acc_reg >>> 8;
    assign sat_hi    = ~mix_shift[PW-1] && (|mix_shift[PW-2:SW-1]);
    assign sat_lo    = mix_shift[PW-1] && ~(&mix_shift[PW-2:SW-1]);
    assign mix_sat   = sat_hi ? {1'b0, {(SW-1){1'b1}}}
                     : (sat_lo ? {1'b1, {(SW-1){1'b0}}} : mix_shift[SW-1:0]);

    // Sequence the steps and update envelope, hold and gate state
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        env_next  = env_reg;
        gate_next = gate_reg;
        hold_next = hold_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = ST_ENV_MUL0;
        end else if (busy_reg) begin
            step_next = step_reg + 4'd1;
            case (step_reg)
                ST_GATE_HOLD: begin
                    env_next  = env_new;
                    hold_next = gate_open ? hold_eff - 1'b1 : hold_eff;
                end
                ST_GATE_UPD: begin
                    gate_next = open_reg ? gate_reg + gate_step : gate_reg - gate_step;
                end
                ST_OUT_R: begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: begin
                    step_next = step_reg + 4'd1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= ST_ENV_MUL0;
            done_reg <= 1'b0;
            env_reg  <= '0;
            gate_reg <= '0;
            hold_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
            env_reg  <= env_next;
            gate_reg <= gate_next;
            hold_reg <= hold_next;
        end
    end

    // Accumulate products and capture intermediate results
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            case (step_reg)
                ST_ENV_MUL0: begin
                    att_reg <= att;
                    acc_reg <= prod;
                end
                ST_ENV_MUL1: begin
                    acc_reg <= att_reg ? acc_reg + prod : acc_reg;
                end
                ST_GATE_HOLD: begin
                    open_reg <= gate_open;
                end
                ST_GATE_MUL: begin
                    acc_reg <= prod + PW'(65535);
                end
                ST_GATE_UPD: begin
                    acc_reg <= prod;
                end
                ST_WET_GAIN: begin
                    gw_reg <= prod[16 +: SW];
                end
                ST_MIX_L, ST_MIX_R: begin
                    acc_reg <= acc_reg + prod;
                end
                ST_OUT_L: begin
                    lo_reg  <= mix_sat;
                    acc_reg <= prod;
                end
                ST_OUT_R: begin
                    ro_reg <= mix_sat;
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign left_out  = lo_reg;
    assign right_out = ro_reg;

endmodule

FILE: hdl/gated_multitap_reverb_unit.sv
// Channel  | Handshake                    | Payload
// ---------+------------------------------+---------------------------------
// input    | s_valid / s_ready            | s_left_in, s_right_in
// result   | m_valid / m_ready            | m_left_out, m_right_out
// config   | cfg_wr_en (no wait)          | cfg_index, cfg_wdata
//
// Each item passes through the delay line steps on the single delay memory port
// (one write, four tap reads) and then the ten steps of the envelope, gate and mix
// stage, which uses a shared multiplier.
// Synchronous active-low reset; the delay memory needs no clearing pass,
// entries not yet written read as zero through the write pointer and wrap flag.
// A finished result waits in the output register while the next item is taken;
// a second result stalls the stage until the first one is transferred.
module gated_multitap_reverb_unit #(
    parameter int DELAY_DEPTH  = gmr_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = gmr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_right_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    m_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]    m_right_out,
    input  logic                              cfg_wr_en,
    input  logic [gmr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gmr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import gmr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TAPS = 2'd1;
    localparam logic [1:0] ST_MIX  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic                           m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] left_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_left_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_right_reg;

    logic [ROOM_W-1:0]   room_size_reg;
    logic [THRESH_W-1:0] gate_threshold_reg;
    logic [ATTACK_W-1:0] attack_coeff_reg;
    logic [HOLD_W-1:0]   hold_samples_reg;
    logic [MIX_W-1:0]    mix_level_reg;

    logic                           s_fire;
    logic                           taps_done;
    logic                           mix_start;
    logic                           mix_done;
    logic                           out_load;
    logic signed [SAMPLE_WIDTH:0]   pair_sum;
    logic signed [SAMPLE_WIDTH-1:0] mono;
    logic signed [SAMPLE_WIDTH-1:0] wet;
    logic signed [SAMPLE_WIDTH-1:0] mix_left;
    logic signed [SAMPLE_WIDTH-1:0] mix_right;
    gmr_gate_cfg_t                  gate_cfg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign mix_start = (state_reg == ST_TAPS) && taps_done;
    assign out_load  = (((state_reg == ST_MIX) && mix_done) || (state_reg == ST_HOLD))
                     && (!m_valid_reg || m_ready);

    // Average the pair to mono (floor of the half sum)
    assign pair_sum = {left_reg[SAMPLE_WIDTH-1], left_reg}
                    + {right_reg[SAMPLE_WIDTH-1], right_reg};
    assign mono     = pair_sum[SAMPLE_WIDTH:1];

    assign gate_cfg.gate_threshold = gate_threshold_reg;
    assign gate_cfg.attack_coeff   = attack_coeff_reg;
    assign gate_cfg.hold_samples   = hold_samples_reg;
    assign gate_cfg.mix_level      = mix_level_reg;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            room_size_reg      <= ROOM_SIZE_RST;
            gate_threshold_reg <= GATE_THRESHOLD_RST;
            attack_coeff_reg   <= ATTACK_COEFF_RST;
            hold_samples_reg   <= HOLD_SAMPLES_RST;
            mix_level_reg      <= MIX_LEVEL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROOM_SIZE:      room_size_reg      <= cfg_wdata[ROOM_W-1:0];
                REG_GATE_THRESHOLD: gate_threshold_reg <= cfg_wdata[THRESH_W-1:0];
                REG_ATTACK_COEFF:   attack_coeff_reg   <= cfg_wdata[ATTACK_W-1:0];
                REG_HOLD_SAMPLES:   hold_samples_reg   <= cfg_wdata[HOLD_W-1:0];
                REG_MIX_LEVEL:      mix_level_reg      <= cfg_wdata[MIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance through taps, gain stage and output hand-off
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_TAPS;
                end
            end
            ST_TAPS: begin
                if (taps_done) begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                if (mix_done) begin
                    state_next = out_load ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the input pair and the finished result
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            left_reg  <= s_left_in;
            right_reg <= s_right_in;
        end
        if (out_load) begin
            out_left_reg  <= mix_left;
            out_right_reg <= mix_right;
        end
    end

    gmr_delay_line #(
        .DEPTH (DELAY_DEPTH),
        .SW    (SAMPLE_WIDTH)
    ) u_delay_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_fire),
        .mono      (mono),
        .room_size (room_size_reg),
        .done      (taps_done),
        .wet       (wet)
    );

    gmr_gate_mix #(
        .SW (SAMPLE_WIDTH)
    ) u_gate_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mix_start),
        .wet       (wet),
        .left_dry  (left_reg),
        .right_dry (right_reg),
        .cfg       (gate_cfg),
        .done      (mix_done),
        .left_out  (mix_left),
        .right_out (mix_right)
    );

    assign m_valid     = m_valid_reg;
    assign m_left_out  = out_left_reg;
    assign m_right_out = out_right_reg;

endmodule

FILE: hdl/gmr_checker.sv
module gmr_checker #(
    parameter int SAMPLE_WIDTH = gmr_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH-1:0] m_left_out,
    input logic signed [SAMPLE_WIDTH-1:0] m_right_out
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_out) && $stable(m_right_out))
        else $error("result changed while stalled");

    // Come out of reset ready with no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("bad state after reset");

    // Take one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input transfer while busy");

    // Never show a result right after an input transfer
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("result appeared too early");

endmodule

bind gated_multitap_reverb_unit gmr_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_gmr_checker (.*);
